>>> design/mnzc_pkg.sv
`default_nettype none
package mnzc_pkg;

   localparam int MAX_UNITS       = 1024;
   localparam int MAX_UNIT_LENGTH = 1024;
   localparam int ADDR_W          = $clog2(MAX_UNITS);

   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int TOTAL_W = 21;
   localparam int SIZE_W  = 11;

   localparam logic [SIZE_W-1:0] UNITS_LIMIT  = SIZE_W'(MAX_UNITS);
   localparam logic [SIZE_W-1:0] LENGTH_LIMIT = SIZE_W'(MAX_UNIT_LENGTH);

   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIRECTION    = 2'd0,
      CSR_UNITS_IN_USE = 2'd1,
      CSR_UNIT_LENGTH  = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_ELEMENT = 1'b0,
      KIND_READ    = 1'b1
   } kind_type;

   typedef enum logic {
      DIR_ROW    = 1'b0,
      DIR_COLUMN = 1'b1
   } dir_type;

   typedef struct packed {
      logic                kind;
      logic [31:0]         element_bits;
      logic [INDEX_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic                is_read_reply;
      logic                unit_done;
      logic                matrix_done;
      logic [INDEX_W-1:0]  unit_index;
      logic [COUNT_W-1:0]  unit_count;
      logic [TOTAL_W-1:0]  total_count;
   } rsp_type;

   typedef struct packed {
      logic                is_read;
      logic                row_mode;
      logic                first_col;
      logic                nz;
      logic                wr_en;
      logic                has_result;
      logic                unit_done;
      logic                matrix_done;
      logic                in_range;
      logic [INDEX_W-1:0]  index;
      logic [ADDR_W-1:0]   addr;
      logic [COUNT_W-1:0]  count;
      logic [TOTAL_W-1:0]  total;
   } stage_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > limit) begin
         r = limit;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/mnzc_ram.sv
`default_nettype none
module mnzc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/matrix_nonzero_counter.sv
`default_nettype none
// Counts nonzero single-precision elements of a column-major matrix, one word per clock unless
// a waiting result stalls it. In row mode each row's count lives in a 1024-entry count memory
// that is read, updated and written back; in column mode the running column count sits in a
// register and is written to the memory as each column ends. A read word returns a stored count.
// The memory has one read and one write port and a registered read; a write-to-read bypass covers
// back-to-back hits on one entry. A result passes through stage s1 and an output register to rsp;
// that register lets req flow while a result waits, until the next result reaches s1. The memory
// needs no clearing after reset. A csr write to a defined index restarts the matrix.
module matrix_nonzero_counter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire mnzc_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output mnzc_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mnzc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [mnzc_pkg::SIZE_W-1:0]         csr_data
);

   localparam int AW = mnzc_pkg::ADDR_W;
   localparam int IW = mnzc_pkg::INDEX_W;
   localparam int CW = mnzc_pkg::COUNT_W;
   localparam int TW = mnzc_pkg::TOTAL_W;
   localparam int SW = mnzc_pkg::SIZE_W;

   logic                  direction_ff, direction_in;
   logic [SW-1:0]         units_ff, units_in;
   logic [SW-1:0]         length_ff, length_in;
   logic [IW-1:0]         row_pos_ff, row_pos_in;
   logic [IW-1:0]         col_pos_ff, col_pos_in;
   logic [CW-1:0]         col_count_ff, col_count_in;
   logic [TW-1:0]         total_ff, total_in;
   logic                  s1_valid_ff, s1_valid_in;
   mnzc_pkg::stage_type   s1_ff, s1_in;
   logic                  fwd_hit_ff, fwd_hit_in;
   logic [CW-1:0]         fwd_data_ff, fwd_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mnzc_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  req_fire, elem_fire, csr_fire, s1_adv;
   logic                  nz, first, last_row, last_col, row_mode;
   logic [SW-1:0]         rows, cols;
   logic [TW-1:0]         total_next;
   logic [CW-1:0]         col_count_next;
   logic [AW-1:0]         rd_addr;
   logic [CW-1:0]         ram_rd, cur_count, new_count, reply_count;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign s1_adv    = s1_valid_ff & (~s1_ff.has_result | ~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign req_fire  = req_valid & req_ready;
   assign elem_fire = req_fire & (req_data.kind == mnzc_pkg::KIND_ELEMENT);
   assign row_mode  = (direction_ff == mnzc_pkg::DIR_ROW);

   always_comb begin
      rows = row_mode ? units_ff : length_ff;
      cols = row_mode ? length_ff : units_ff;
      nz   = |req_data.element_bits[30:0];
      first = (row_pos_ff == '0) && (col_pos_ff == '0);
      total_next = first ? TW'(nz) : total_ff + TW'(nz);
      last_row = (SW'(row_pos_ff) + SW'(1)) >= rows;
      last_col = (SW'(col_pos_ff) + SW'(1)) >= cols;
      col_count_next = (row_pos_ff == '0) ? CW'(nz) : col_count_ff + CW'(nz);
      rd_addr = (req_data.kind == mnzc_pkg::KIND_READ) ? AW'(req_data.read_index)
                                                       : AW'(row_pos_ff);
   end

   always_comb begin
      direction_in = direction_ff;
      units_in     = units_ff;
      length_in    = length_ff;
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      col_count_in = col_count_ff;
      total_in     = total_ff;
      if (csr_fire) begin
         case (csr_index)
            mnzc_pkg::CSR_DIRECTION: begin
               direction_in = csr_data[0];
               row_pos_in   = '0;
               col_pos_in   = '0;
               col_count_in = '0;
            end
            mnzc_pkg::CSR_UNITS_IN_USE: begin
               units_in     = mnzc_pkg::clamp_size(csr_data, mnzc_pkg::UNITS_LIMIT);
               row_pos_in   = '0;
               col_pos_in   = '0;
               col_count_in = '0;
            end
            mnzc_pkg::CSR_UNIT_LENGTH: begin
               length_in    = mnzc_pkg::clamp_size(csr_data, mnzc_pkg::LENGTH_LIMIT);
               row_pos_in   = '0;
               col_pos_in   = '0;
               col_count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (elem_fire) begin
         total_in = total_next;
         if (!row_mode) begin
            col_count_in = col_count_next;
         end
         if (last_row) begin
            row_pos_in = '0;
            col_pos_in = last_col ? '0 : col_pos_ff + IW'(1);
         end else begin
            row_pos_in = row_pos_ff + IW'(1);
         end
      end
   end

   always_comb begin
      s1_in             = s1_ff;
      s1_valid_in       = s1_valid_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in       = 1'b1;
         s1_in.is_read     = (req_data.kind == mnzc_pkg::KIND_READ);
         s1_in.row_mode    = row_mode;
         s1_in.first_col   = (col_pos_ff == '0);
         s1_in.nz          = nz;
         s1_in.in_range    = (32'(req_data.read_index) < 32'(mnzc_pkg::MAX_UNITS));
         s1_in.count       = col_count_next;
         if (req_data.kind == mnzc_pkg::KIND_READ) begin
            s1_in.wr_en       = 1'b0;
            s1_in.has_result  = 1'b1;
            s1_in.unit_done   = 1'b0;
            s1_in.matrix_done = 1'b0;
            s1_in.index       = req_data.read_index;
            s1_in.total       = total_ff;
         end else if (row_mode) begin
            s1_in.wr_en       = 1'b1;
            s1_in.has_result  = last_row & last_col;
            s1_in.unit_done   = 1'b0;
            s1_in.matrix_done = 1'b1;
            s1_in.index       = row_pos_ff;
            s1_in.total       = total_next;
         end else begin
            s1_in.wr_en       = last_row;
            s1_in.has_result  = last_row;
            s1_in.unit_done   = 1'b1;
            s1_in.matrix_done = last_col;
            s1_in.index       = col_pos_ff;
            s1_in.total       = total_next;
         end
         s1_in.addr = (req_data.kind == mnzc_pkg::KIND_READ) ? rd_addr
                                                             : AW'(s1_in.index);
      end
   end

   always_comb begin
      cur_count = fwd_hit_ff ? fwd_data_ff : ram_rd;
      if (s1_ff.row_mode) begin
         new_count = s1_ff.first_col ? CW'(s1_ff.nz) : cur_count + CW'(s1_ff.nz);
      end else begin
         new_count = s1_ff.count;
      end
      reply_count = s1_ff.is_read ? (s1_ff.in_range ? cur_count : '0) : new_count;
      fwd_hit_in  = s1_adv & s1_ff.wr_en & (s1_ff.addr == rd_addr);
      fwd_data_in = new_count;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_adv && s1_ff.has_result) begin
         rsp_valid_in         = 1'b1;
         rsp_in.is_read_reply = s1_ff.is_read;
         rsp_in.unit_done     = s1_ff.unit_done;
         rsp_in.matrix_done   = s1_ff.matrix_done;
         rsp_in.unit_index    = s1_ff.index;
         rsp_in.unit_count    = reply_count;
         rsp_in.total_count   = s1_ff.total;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= mnzc_pkg::DIR_ROW;
         units_ff     <= SW'(1);
         length_ff    <= SW'(1);
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         col_count_ff <= '0;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         units_ff     <= units_in;
         length_ff    <= length_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         col_count_ff <= col_count_in;
         total_ff     <= total_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
      if (req_fire) begin
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= fwd_data_in;
      end
   end

   mnzc_ram #(
      .WIDTH (CW),
      .DEPTH (mnzc_pkg::MAX_UNITS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (s1_adv & s1_ff.wr_en),
      .wr_addr (s1_ff.addr),
      .wr_data (new_count),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
